/* sv/apgec_pkg.sv */
// Package: shared types, codes and constants of the ADC pedestal, gain and energy calibration.
package apgec_pkg;

   // Default build values for the top-level parameters
   localparam int DEF_CHANNELS = 8;
   localparam int DEF_MAX_HITS = 255;

   // Fixed field and state widths
   localparam int SUM_W       = 48;
   localparam int CNT_W       = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 40;

   // Operation codes of an input item
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_HIT  = 2'd1;
   localparam logic [1:0] OP_END  = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ECAL_OFFSET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ECAL_LINEAR = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ECAL_SQUARE = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic [2:0]         channel;
      logic [15:0]        adc_raw;
      logic [23:0]        pedestal;
      logic [17:0]        gain_drift;
      logic signed [31:0] match_c0;
      logic signed [31:0] match_c1;
      logic signed [39:0] match_c2;
   } req_payload_type;

   typedef struct packed {
      logic [39:0]        adc_average;
      logic signed [31:0] core_energy;
      logic [7:0]         hit_count;
   } rsp_payload_type;

   // One channel's coefficient set as held in the coefficient RAM
   typedef struct packed {
      logic [23:0]        pedestal;
      logic [17:0]        gain_drift;
      logic signed [31:0] match_c0;
      logic signed [31:0] match_c1;
      logic signed [39:0] match_c2;
   } coef_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCALE,
      ST_DIV,
      ST_POLY,
      ST_FIN
   } state_type;

endpackage

/* sv/adc_pedestal_gain_energy_calib.sv */
// Top level: per-event detector core energy from pedestal-, drift- and gain-matched ADC hits.
//
// A load item writes a channel's pedestal, gain drift and quadratic gain-match coefficients
// into a single coefficient RAM of CHANNELS entries with a registered read port; loads and
// hits for a channel at or above CHANNELS are dropped. A hit item reads its channel's entry,
// forms x = (adc*256 - pedestal) * drift >> 8 (clamped to 0 .. 2^31-1), evaluates
// y = c0 + c1*x + c2*x^2 in Q16.16 (clamped to 0 .. 2^32-1) and adds y to a saturating 48-bit
// event sum; it passes through the RAM read, one scaling multiply and seven steps of the one
// shared 32 x 32 multiplier that the polynomial uses. Hits beyond min(MAX_HITS, 255) in an
// event are dropped. An end-of-event item takes the event sum and hit count and clears the
// event as it is accepted, divides the sum by the hit count in a bit-serial divider (skipped
// when there were no hits), clamps the mean to 32 bits, runs the same polynomial with the
// energy registers and presents adc_average, core_energy and hit_count on the result channel
// once the result register has passed on its previous result. Load, hit and unknown operations
// give no result. The input is stalled while an item is in progress; a finished result waits in
// its own register so the next item can be taken before it is transferred. Write the energy
// registers only while the block is idle.
module adc_pedestal_gain_energy_calib #(
   parameter int CHANNELS = apgec_pkg::DEF_CHANNELS,
   parameter int MAX_HITS = apgec_pkg::DEF_MAX_HITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  apgec_pkg::req_payload_type          req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output apgec_pkg::rsp_payload_type          rsp_payload,
   input  logic                                csr_we,
   input  logic [apgec_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [apgec_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import apgec_pkg::*;

   localparam int AddrW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int HitLimit = (MAX_HITS < 255) ? MAX_HITS : 255;
   localparam int DivCntW  = $clog2(SUM_W);

   // Polynomial sequencer steps on the shared multiplier
   localparam logic [2:0] PS_LIN_MUL = 3'd0;   // issue |c1| * v
   localparam logic [2:0] PS_LIN_ACC = 3'd1;   // fold linear term into base, issue low |c2| * v
   localparam logic [2:0] PS_W_LO    = 3'd2;   // hold low partial of w = |c2| * v
   localparam logic [2:0] PS_W_HI    = 3'd3;   // complete w, issue w[31:0] * v
   localparam logic [2:0] PS_Q0      = 3'd4;   // start q = w * v, issue w[63:32] * v
   localparam logic [2:0] PS_Q1      = 3'd5;   // issue w[71:64] * v
   localparam logic [2:0] PS_Q2      = 3'd6;   // last partial of q

   // Control state
   state_type              state_ff, state_in;
   logic [2:0]             step_ff, step_in;
   logic [DivCntW-1:0]     div_cnt_ff;
   logic                   end_mode_ff;
   logic                   rsp_valid_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [CNT_W-1:0]       hits_ff;

   // Configuration
   logic signed [31:0]     ecal_offset_ff;
   logic signed [31:0]     ecal_linear_ff;
   logic signed [39:0]     ecal_square_ff;

   // Coefficient RAM and datapath
   coef_entry_type         coef_ram_ff [CHANNELS];
   coef_entry_type         coef_q_ff;
   logic [AddrW-1:0]       ram_addr;
   logic [15:0]            adc_ff;
   logic [63:0]            prod_ff;
   logic [31:0]            mul_a, mul_b;
   logic [31:0]            v_ff;
   logic signed [48:0]     base_ff;
   logic [103:0]           acc_ff;
   logic [71:0]            w_ff;
   logic [SUM_W-1:0]       quo_ff;
   logic [CNT_W-1:0]       rem_ff;
   logic [CNT_W-1:0]       dvs_ff;
   logic [31:0]            avg_ff;
   logic [CNT_W-1:0]       cnt_out_ff;
   rsp_payload_type        rsp_payload_ff;

   // Handshake and decode
   logic                   accept, ch_ok, load_go, hit_go, end_go;
   logic                   out_free, out_load, sum_update, div_last;

   // Arithmetic
   logic signed [24:0]     diff;
   logic                   diff_pos;
   logic [30:0]            x_sat;
   logic [CNT_W:0]         trial;
   logic                   trial_ge;
   logic [CNT_W-1:0]       rem_in;
   logic [SUM_W-1:0]       quo_in;
   logic [31:0]            avg_clamp;
   logic signed [31:0]     c0_sel, c1_sel;
   logic signed [39:0]     c2_sel;
   logic [31:0]            c1_mag;
   logic [39:0]            c2_mag;
   logic signed [48:0]     lin_s;
   logic signed [48:0]     base_in;
   logic signed [57:0]     quad_s, total;
   logic [31:0]            y_clamp;
   logic [SUM_W:0]         sum_wide;
   logic signed [31:0]     energy_sat;

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign ch_ok       = (32'(req_payload.channel) < CHANNELS);
   assign load_go     = accept && (req_payload.operation == OP_LOAD) && ch_ok;
   assign hit_go      = accept && (req_payload.operation == OP_HIT) && ch_ok
                        && (hits_ff < CNT_W'(HitLimit));
   assign end_go      = accept && (req_payload.operation == OP_END);
   assign ram_addr    = AddrW'(req_payload.channel);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign div_last    = (div_cnt_ff == DivCntW'(SUM_W - 1));

   // Pedestal subtraction and drift scaling
   assign diff     = $signed({1'b0, adc_ff, 8'b0}) - $signed({1'b0, coef_q_ff.pedestal});
   assign diff_pos = !diff[24] && (diff != '0);
   assign x_sat    = (prod_ff[63:39] != '0) ? {31{1'b1}} : prod_ff[38:8];

   // Bit-serial restoring division of the event sum by the hit count
   assign trial     = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_ge  = (trial >= {1'b0, dvs_ff});
   assign rem_in    = trial_ge ? CNT_W'(trial - {1'b0, dvs_ff}) : trial[CNT_W-1:0];
   assign quo_in    = {quo_ff[SUM_W-2:0], trial_ge};
   assign avg_clamp = (quo_in[SUM_W-1:32] != '0) ? 32'hFFFF_FFFF : quo_in[31:0];

   // Coefficients: channel entry for a hit, energy registers at end of event
   assign c0_sel = end_mode_ff ? ecal_offset_ff : coef_q_ff.match_c0;
   assign c1_sel = end_mode_ff ? ecal_linear_ff : coef_q_ff.match_c1;
   assign c2_sel = end_mode_ff ? ecal_square_ff : coef_q_ff.match_c2;
   assign c1_mag = c1_sel[31] ? 32'(-c1_sel) : 32'(c1_sel);
   assign c2_mag = c2_sel[39] ? 40'(-c2_sel) : 40'(c2_sel);

   // Products are truncated in magnitude, then take the coefficient's sign
   assign lin_s   = $signed({1'b0, prod_ff[63:16]});
   assign base_in = $signed({{17{c0_sel[31]}}, c0_sel}) + (c1_sel[31] ? -lin_s : lin_s);
   assign quad_s  = $signed({2'b00, acc_ff[103:48]});
   assign total   = $signed({{9{base_ff[48]}}, base_ff}) + (c2_sel[39] ? -quad_s : quad_s);

   always_comb begin
      if (total[57]) begin
         y_clamp = '0;
      end else if (total[56:32] != '0) begin
         y_clamp = 32'hFFFF_FFFF;
      end else begin
         y_clamp = total[31:0];
      end
   end

   always_comb begin
      if (!total[57] && (total[56:31] != '0)) begin
         energy_sat = 32'sh7FFF_FFFF;
      end else if (total[57] && (total[56:31] != {26{1'b1}})) begin
         energy_sat = 32'sh8000_0000;
      end else begin
         energy_sat = total[31:0];
      end
   end

   assign sum_wide = {1'b0, sum_ff} + {17'b0, y_clamp};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (hit_go) begin
               state_in = ST_READ;
            end else if (end_go) begin
               state_in = (hits_ff != '0) ? ST_DIV : ST_POLY;
            end
         end
         ST_READ:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_POLY;
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_POLY;
            end
         end
         ST_POLY: begin
            if (step_ff == PS_Q2) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!end_mode_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Multiplier operands and completion strobes
   always_comb begin
      mul_a      = '0;
      mul_b      = v_ff;
      out_load   = 1'b0;
      sum_update = 1'b0;
      step_in    = '0;
      case (state_ff)
         ST_READ: begin
            mul_a = diff_pos ? {8'b0, diff[23:0]} : '0;
            mul_b = {14'b0, coef_q_ff.gain_drift};
         end
         ST_POLY: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               PS_LIN_MUL: mul_a = c1_mag;
               PS_LIN_ACC: mul_a = c2_mag[31:0];
               PS_W_LO:    mul_a = {24'b0, c2_mag[39:32]};
               PS_W_HI:    mul_a = acc_ff[31:0];
               PS_Q0:      mul_a = w_ff[63:32];
               PS_Q1:      mul_a = {24'b0, w_ff[71:64]};
               default:    mul_a = '0;
            endcase
         end
         ST_FIN: begin
            out_load   = end_mode_ff && out_free;
            sum_update = !end_mode_ff;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // Coefficient RAM: write on load, registered read on hit
   always_ff @(posedge clock) begin
      if (load_go) begin
         coef_ram_ff[ram_addr] <= '{pedestal:   req_payload.pedestal,
                                    gain_drift: req_payload.gain_drift,
                                    match_c0:   req_payload.match_c0,
                                    match_c1:   req_payload.match_c1,
                                    match_c2:   req_payload.match_c2};
      end
      if (hit_go) begin
         coef_q_ff <= coef_ram_ff[ram_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         div_cnt_ff   <= '0;
         end_mode_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         hits_ff      <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (state_ff == ST_DIV) begin
            div_cnt_ff <= div_cnt_ff + DivCntW'(1);
         end else begin
            div_cnt_ff <= '0;
         end
         if (hit_go) begin
            end_mode_ff <= 1'b0;
         end else if (end_go) begin
            end_mode_ff <= 1'b1;
         end
         // Clear the event once its sum and count are captured
         if (end_go) begin
            sum_ff  <= '0;
            hits_ff <= '0;
         end else if (sum_update) begin
            sum_ff  <= sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
            hits_ff <= hits_ff + CNT_W'(1);
         end
         // Hold the result until its transfer
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Energy calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ecal_offset_ff <= '0;
         ecal_linear_ff <= '0;
         ecal_square_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ECAL_OFFSET: ecal_offset_ff <= csr_wdata[31:0];
            CSR_ECAL_LINEAR: ecal_linear_ff <= csr_wdata[31:0];
            CSR_ECAL_SQUARE: ecal_square_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= {32'b0, mul_a} * {32'b0, mul_b};
      if (hit_go) begin
         adc_ff <= req_payload.adc_raw;
      end
      if (end_go) begin
         cnt_out_ff <= hits_ff;
         quo_ff     <= sum_ff;
         rem_ff     <= '0;
         dvs_ff     <= hits_ff;
         avg_ff     <= '0;
         v_ff       <= '0;
      end
      case (state_ff)
         ST_SCALE: v_ff <= {1'b0, x_sat};
         ST_DIV: begin
            quo_ff <= quo_in;
            rem_ff <= rem_in;
            if (div_last) begin
               avg_ff <= avg_clamp;
               v_ff   <= avg_clamp;
            end
         end
         ST_POLY: begin
            case (step_ff)
               PS_LIN_ACC: base_ff <= base_in;
               PS_W_LO:    acc_ff  <= {40'b0, prod_ff};
               PS_W_HI:    w_ff    <= acc_ff[71:0] + {prod_ff[39:0], 32'b0};
               PS_Q0:      acc_ff  <= {40'b0, prod_ff};
               PS_Q1:      acc_ff  <= acc_ff + {8'b0, prod_ff, 32'b0};
               PS_Q2:      acc_ff  <= acc_ff + {prod_ff[39:0], 64'b0};
               default: ;
            endcase
         end
         default: ;
      endcase
      if (out_load) begin
         rsp_payload_ff.adc_average <= {8'b0, avg_ff};
         rsp_payload_ff.core_energy <= energy_sat;
         rsp_payload_ff.hit_count   <= cnt_out_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* sv/apgec_checker.sv */
// Checker: port-level properties of the calibration block, bound to its top level.
module apgec_checker #(
   parameter int MAX_HITS = apgec_pkg::DEF_MAX_HITS
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input apgec_pkg::req_payload_type          req_payload,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input apgec_pkg::rsp_payload_type          rsp_payload,
   input logic                                csr_we,
   input logic [apgec_pkg::CSR_INDEX_W-1:0]   csr_index,
   input logic [apgec_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import apgec_pkg::*;

   localparam int HitLimit = (MAX_HITS < 255) ? MAX_HITS : 255;

   // A stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed or dropped while stalled");

   // The hit count never passes the event limit
   a_hit_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.hit_count <= CNT_W'(HitLimit)))
      else $error("hit count above event limit");

   // An empty event has a zero average
   a_empty_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.hit_count == '0) |-> (rsp_payload.adc_average == '0))
      else $error("non-zero average for an event without hits");

   // The average is clamped to 32 bits
   a_avg_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.adc_average[39:32] == '0))
      else $error("average above the 32-bit clamp");

   // End of event always takes more than the accepting cycle
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_payload.operation == OP_END) |=> req_stall)
      else $error("input not stalled after end-of-event transfer");

   // Configuration port is unconstrained here
   logic unused_csr;
   assign unused_csr = csr_we ^ (^csr_index) ^ (^csr_wdata);

endmodule

bind adc_pedestal_gain_energy_calib apgec_checker #(.MAX_HITS(MAX_HITS)) u_apgec_checker (.*);

/* dv/adc_pedestal_gain_energy_calib_test.sv */
// Self-checking testbench for the ADC pedestal, gain-match and energy calibration block.
`timescale 1ns / 1ps

module adc_pedestal_gain_energy_calib_test;
   import apgec_pkg::*;

   // Operation code that the block must drop without a result
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int HIT_CAP = (DEF_MAX_HITS < 255) ? DEF_MAX_HITS : 255;
   // Idle cycles to allow before a register write: an end of event with hits may still be in
   // progress, and its result may still wait behind the previous transfer.
   localparam int SETTLE_CYCLES = 100;
   // Cycles without any transfer before the run is declared hung
   localparam int QUIET_LIMIT = 2000;
   localparam int PRINT_LIMIT = 200;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Stimulus waiting to be offered, and end-of-event reports still owed by the block
   req_payload_type detector_items[$];
   rsp_payload_type awaited_reports[$];

   // Predicted state: coefficient store, event accumulator and energy registers
   coef_entry_type     coef_store [8];
   logic [SUM_W-1:0]   event_sum = '0;
   logic [CNT_W-1:0]   event_hits = '0;
   logic signed [31:0] energy_offset = '0;
   logic signed [39:0] energy_square = '0;
   logic signed [31:0] energy_linear = '0;

   logic [23:0]     staged_ped [8];
   bit              relaxed = 1'b0;
   int              send_gap = 0;
   int              hold_left = 0;
   int              quiet_cycles = 0;
   int              mismatches = 0;
   rsp_payload_type due;

   adc_pedestal_gain_energy_calib uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------------------------

   // (coef * operand) >> shift, magnitude truncated towards zero and capped at 2^62
   function automatic longint scaled_product(longint coef, logic [63:0] operand,
                                             int unsigned shift);
      logic [127:0] wide;
      logic [63:0]  mag;
      mag = (coef < 0) ? -coef : coef;
      wide = {64'd0, mag} * {64'd0, operand};
      wide = wide >> shift;
      if (wide > 128'h4000_0000_0000_0000) wide = 128'h4000_0000_0000_0000;
      return (coef < 0) ? -longint'(wide[63:0]) : longint'(wide[63:0]);
   endfunction

   // Pedestal subtraction, drift scaling and the quadratic gain match of one hit
   function automatic logic [31:0] matched_gain(coef_entry_type c, logic [15:0] adc);
      longint      diff;
      longint      level;
      logic [63:0] x;
      diff = {adc, 8'd0};
      diff = diff - c.pedestal;
      if (diff <= 0) begin
         x = '0;
      end else begin
         x = (64'(diff) * c.gain_drift) >> 8;
         if (x > 64'h7FFF_FFFF) x = 64'h7FFF_FFFF;
      end
      level = $signed(c.match_c0) + scaled_product($signed(c.match_c1), x, 16)
            + scaled_product($signed(c.match_c2), x * x, 48);
      if (level < 0) return '0;
      if (level > 64'sh0_FFFF_FFFF) return '1;
      return level[31:0];
   endfunction

   // Advance the predicted state by one accepted transfer; queue a report on end of event.
   // Channel is three bits wide, so it is always below the default channel count.
   task automatic calibrate_item(req_payload_type it);
      logic [SUM_W:0]  grown;
      logic [63:0]     mean;
      longint          energy;
      rsp_payload_type rep;
      case (it.operation)
         OP_LOAD: begin
            coef_store[it.channel] = '{it.pedestal, it.gain_drift, it.match_c0, it.match_c1,
                                       it.match_c2};
         end
         OP_HIT: begin
            // drop hits once the event count is full
            if (event_hits < HIT_CAP) begin
               grown = event_sum + matched_gain(coef_store[it.channel], it.adc_raw);
               event_sum = grown[SUM_W] ? '1 : grown[SUM_W-1:0];
               event_hits = event_hits + 1'b1;
            end
         end
         OP_END: begin
            mean = (event_hits != 0) ? event_sum / event_hits : 64'd0;
            if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
            energy = energy_offset + scaled_product(energy_linear, mean, 16)
                   + scaled_product(energy_square, mean * mean, 48);
            if (energy > 64'sd2147483647) energy = 64'sd2147483647;
            else if (energy < -64'sd2147483648) energy = -64'sd2147483648;
            rep.adc_average = mean[39:0];
            rep.core_energy = energy[31:0];
            rep.hit_count   = event_hits;
            awaited_reports.push_back(rep);
            event_sum = '0;
            event_hits = '0;
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------------------------

   // Idle length for either side: mostly none, sometimes a few cycles, rarely a long one
   function automatic int idle_length();
      int r;
      if (relaxed) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] coef32();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         5: return 32'h0001_0000 + $urandom_range(0, 32'hFFFF) - 32'h8000;
         default: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
      endcase
   endfunction

   function automatic logic [39:0] coef40();
      case ($urandom_range(0, 4))
         0: return 40'({$urandom, $urandom});
         1: return 40'h80_0000_0000;
         2: return 40'h7F_FFFF_FFFF;
         default: return 40'(longint'(int'($urandom_range(0, 8192)) - 4096));
      endcase
   endfunction

   // Every field random; the block ignores the ones the operation does not use
   function automatic req_payload_type noise_item(logic [1:0] op, logic [2:0] ch);
      req_payload_type it;
      it.operation  = op;
      it.channel    = ch;
      it.adc_raw    = $urandom;
      it.pedestal   = $urandom;
      it.gain_drift = $urandom;
      it.match_c0   = $urandom;
      it.match_c1   = $urandom;
      it.match_c2   = 40'({$urandom, $urandom});
      return it;
   endfunction

   task automatic stage(req_payload_type it);
      if (it.operation == OP_LOAD) staged_ped[it.channel] = it.pedestal;
      detector_items.push_back(it);
   endtask

   task automatic load_set(logic [2:0] ch, logic [23:0] ped, logic [17:0] drift,
                           logic [31:0] c0, logic [31:0] c1, logic [39:0] c2);
      req_payload_type it;
      it = noise_item(OP_LOAD, ch);
      it.pedestal   = ped;
      it.gain_drift = drift;
      it.match_c0   = c0;
      it.match_c1   = c1;
      it.match_c2   = c2;
      stage(it);
   endtask

   task automatic load_random(logic [2:0] ch);
      load_set(ch,
               $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 24'h3_FFFF)),
               $urandom_range(0, 1) ? 18'($urandom) : 18'($urandom_range(32'h8000, 32'h1_8000)),
               coef32(), coef32(), coef40());
   endtask

   task automatic hit_at(logic [2:0] ch, logic [15:0] adc);
      req_payload_type it;
      it = noise_item(OP_HIT, ch);
      it.adc_raw = adc;
      stage(it);
   endtask

   // Small counts, full-scale counts and counts just above the channel's pedestal
   task automatic hit_random();
      logic [2:0] ch;
      ch = $urandom;
      case ($urandom_range(0, 3))
         0: hit_at(ch, $urandom);
         1: hit_at(ch, $urandom_range(0, 255));
         default: hit_at(ch, 16'(staged_ped[ch][23:8] + $urandom_range(0, 300)));
      endcase
   endtask

   task automatic close_event();
      stage(noise_item(OP_END, $urandom));
   endtask

   task automatic long_event(int hits);
      repeat (hits) hit_random();
      close_event();
   endtask

   // Mostly whole events with random content; the rest stray loads, empty ends and unused codes
   task automatic run_random(int target);
      int issued;
      int hits;
      issued = 0;
      while (issued < target) begin
         if ($urandom_range(0, 9) == 0) relaxed = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 4) == 0) begin
               load_random($urandom);
               issued++;
            end
            hits = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
            repeat (hits) begin
               // a reload in the middle of an event
               if ($urandom_range(0, 14) == 0) begin
                  load_random($urandom);
                  issued++;
               end
               hit_random();
            end
            close_event();
            issued += hits + 1;
         end else begin
            case ($urandom_range(0, 2))
               0: begin
                  load_random($urandom);
                  issued++;
               end
               1: begin
                  close_event();
                  issued++;
               end
               default: stage(noise_item(OP_UNUSED, $urandom));
            endcase
         end
      end
   endtask

   // Wait until nothing is owed, then let any hit still in progress finish
   task automatic settle();
      @(negedge clock);
      while (detector_items.size() != 0 || req_valid || awaited_reports.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write all three energy registers while the block is idle; junk above a 32-bit register
   // must be dropped by the block
   task automatic program_energy(logic [31:0] off, logic [31:0] lin, logic [39:0] sq);
      settle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_ECAL_OFFSET;
      csr_wdata <= {8'($urandom), off};
      @(posedge clock);
      csr_index <= CSR_ECAL_LINEAR;
      csr_wdata <= {8'($urandom), lin};
      @(posedge clock);
      csr_index <= CSR_ECAL_SQUARE;
      csr_wdata <= sq;
      @(posedge clock);
      csr_we <= 1'b0;
      energy_offset = off;
      energy_linear = lin;
      energy_square = sq;
      @(negedge clock);
   endtask

   task automatic note_mismatch(string msg);
      mismatches++;
      // keep the log readable if everything goes wrong
      if (mismatches <= PRINT_LIMIT) $display("[%0t] MISMATCH %s", $realtime, msg);
   endtask

   // ------------------------------------------------------------------------------------------
   // Driver: offer queued items, hold a stalled transfer, idle at random after each transfer
   // ------------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            calibrate_item(req_payload);
            send_gap = idle_length();
         end
         // a stalled transfer keeps its payload and valid untouched
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (detector_items.size() != 0) begin
               req_payload <= detector_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------------------------
   // Monitor: check each report against the oldest prediction, stall at random
   // ------------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_reports.size() == 0) begin
               note_mismatch($sformatf("report with none pending: avg %h energy %h hits %0d",
                                       rsp_payload.adc_average, rsp_payload.core_energy,
                                       rsp_payload.hit_count));
            end else begin
               due = awaited_reports.pop_front();
               if (rsp_payload.adc_average !== due.adc_average)
                  note_mismatch($sformatf("adc_average %h, predicted %h",
                                          rsp_payload.adc_average, due.adc_average));
               if (rsp_payload.core_energy !== due.core_energy)
                  note_mismatch($sformatf("core_energy %h, predicted %h",
                                          rsp_payload.core_energy, due.core_energy));
               if (rsp_payload.hit_count !== due.hit_count)
                  note_mismatch($sformatf("hit_count %0d, predicted %0d",
                                          rsp_payload.hit_count, due.hit_count));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            hold_left = idle_length();
         end
      end
   end

   // Count cycles with no transfer on either channel
   always @(posedge clock)
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("[%0t] no transfer for %0d cycles, %0d items unsent, %0d reports outstanding",
               $realtime, QUIET_LIMIT, detector_items.size(), awaited_reports.size());
      $display("adc_pedestal_gain_energy_calib: mismatch");
      $finish;
   end

   // ------------------------------------------------------------------------------------------
   // Sequence: reset, directed items, then random phases under different energy settings
   // ------------------------------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Typical energy calibration: half an MeV offset, unit slope, tiny curvature
      program_energy(32'h0000_8000, 32'h0001_0000, 40'h00_0000_0100);
      relaxed = 1'b0;
      // Fill every channel before any hit so no unwritten entry is ever read
      load_set(3'd0, 24'h00_1000, 18'h1_0000, 32'h0000_0000, 32'h0001_0000, 40'h0);
      load_set(3'd1, 24'h00_0000, 18'h3_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 40'h7F_FFFF_FFFF);
      load_set(3'd2, 24'hFF_FFFF, 18'h3_FFFF, 32'h8000_0000, 32'h8000_0000, 40'h80_0000_0000);
      load_set(3'd3, 24'h00_0080, 18'h0_FF00, 32'h0001_0000, 32'h0000_8000, 40'h00_0000_0400);
      load_set(3'd4, 24'h12_3456, 18'h1_0000, 32'hFFFE_0000, 32'h0001_0000, 40'hFF_FFFF_FFFF);
      load_random(3'd5);
      load_random(3'd6);
      load_random(3'd7);
      // empty event: zero mean, energy is the offset alone
      close_event();
      hit_at(3'd0, 16'h0000);   // below pedestal
      hit_at(3'd0, 16'h0010);   // exactly on the pedestal
      hit_at(3'd0, 16'hFFFF);
      hit_at(3'd1, 16'hFFFF);   // corrected count and gain match both clip high
      hit_at(3'd2, 16'hFFFF);   // below the largest pedestal, negative gain match clips to zero
      hit_at(3'd3, 16'h0001);   // fractional pedestal
      hit_at(3'd4, 16'h1300);   // negative curvature truncates towards zero
      stage(noise_item(OP_UNUSED, 3'd7));
      close_event();
      hit_at(3'd1, 16'hFFFF);   // mean near full scale drives the energy into saturation
      hit_at(3'd1, 16'h8000);
      close_event();
      hit_at(3'd2, 16'h1234);
      close_event();
      run_random(400);

      program_energy(32'h7FFF_FFFF, 32'h7FFF_FFFF, 40'h7F_FFFF_FFFF);
      long_event(HIT_CAP);
      run_random(400);

      program_energy(32'h8000_0000, 32'h8000_0000, 40'h80_0000_0000);
      run_random(400);

      program_energy($urandom, $urandom, 40'({$urandom, $urandom}));
      // run past the hit limit: the extra hits must be dropped
      long_event(HIT_CAP + 3);
      run_random(400);

      program_energy(32'h0, 32'h0, 40'h0);
      run_random(400);

      settle();
      if (mismatches == 0) begin
         $display("adc_pedestal_gain_energy_calib: match");
      end else begin
         $display("adc_pedestal_gain_energy_calib: mismatch");
      end
      $finish;
   end

endmodule
